[rtl/pwf_pkg.sv]
// Shared types and constants for the pulse waveform feature unit.
// Used by every module in rtl/; depends on nothing else.
package pwf_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int SAMPLE_BITS = 12;
    localparam int IDX_W       = $clog2(MAX_SAMPLES + 1);
    localparam int POS_W       = 8;
    localparam int SUM_W       = 20;
    localparam int SQ_W        = 32;
    localparam int CNT_W       = 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = 40;
    localparam int DEN_W       = 16;
    localparam int DIV_W       = 56;
    localparam int ROOT_W      = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 104;

    localparam logic [CFG_IDX_W-1:0] REG_PED_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd2;

    localparam logic [CFG_W-1:0] PED_COUNT_RST   = 8'd125;
    localparam logic [CFG_W-1:0] WINDOW_LOW_RST  = 8'd126;
    localparam logic [CFG_W-1:0] WINDOW_HIGH_RST = 8'd255;

    // Raw accumulator snapshot of one finished waveform
    typedef struct packed {
        logic [SUM_W-1:0]       total;
        logic [SUM_W-1:0]       window;
        logic [SAMPLE_BITS-1:0] peak;
        logic [POS_W-1:0]       pos;
        logic [SUM_W-1:0]       s1;
        logic [SQ_W-1:0]        s2;
        logic [CNT_W-1:0]       cnt;
    } pwf_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pwf_qstat_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] numer;
        logic [DEN_W-1:0] denom;
    } pwf_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } pwf_div_rsp_t;

endpackage

[rtl/pwf_front.sv]
// Front part: configuration registers and per-sample accumulation.
// Pushes one accumulator record per waveform into the queue; uses pwf_pkg.
module pwf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pwf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwf_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pwf_pkg::SAMPLE_BITS-1:0]  sample,
    input  logic                             s_tlast,
    input  pwf_pkg::pwf_qstat_t              q_stat,
    output logic                             q_push,
    output pwf_pkg::pwf_rec_t                q_rec
);
    import pwf_pkg::*;

    logic [CFG_W-1:0]       ped_count_reg;
    logic [CFG_W-1:0]       window_low_reg;
    logic [CFG_W-1:0]       window_high_reg;
    logic [IDX_W-1:0]       idx_reg,    idx_next;
    logic [SUM_W-1:0]       total_reg,  total_next;
    logic [SUM_W-1:0]       window_reg, window_next;
    logic [SUM_W-1:0]       s1_reg,     s1_next;
    logic [SQ_W-1:0]        s2_reg,     s2_next;
    logic [SAMPLE_BITS-1:0] best_reg,   best_next;
    logic [POS_W-1:0]       pos_reg,    pos_next;
    logic                   accept;
    logic                   in_range;
    logic [POS_W-1:0]       idx_low;
    logic [CNT_W-1:0]       cnt;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;
    assign in_range  = (idx_reg < IDX_W'(MAX_SAMPLES));
    assign idx_low   = idx_reg[POS_W-1:0];

    always_comb
    begin
        idx_next    = idx_reg;
        total_next  = total_reg;
        window_next = window_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        best_next   = best_reg;
        pos_next    = pos_reg;
        if (in_range)
        begin
            idx_next   = idx_reg + 1'b1;
            total_next = total_reg + SUM_W'(sample);
            if (idx_low >= window_low_reg && idx_low <= window_high_reg)
                window_next = window_reg + SUM_W'(sample);
            if (idx_reg < IDX_W'(ped_count_reg))
            begin
                s1_next = s1_reg + SUM_W'(sample);
                s2_next = s2_reg + SQ_W'(sample) * SQ_W'(sample);
            end
            if (idx_reg == '0 || sample > best_reg)
            begin
                best_next = sample;
                pos_next  = idx_low;
            end
        end
    end

    // pedestal count is the smaller of the register and the samples seen
    assign cnt = (idx_next < IDX_W'(ped_count_reg)) ? idx_next[CNT_W-1:0] : ped_count_reg;

    assign q_push       = accept && s_tlast;
    assign q_rec.total  = total_next;
    assign q_rec.window = window_next;
    assign q_rec.peak   = best_next;
    assign q_rec.pos    = pos_next;
    assign q_rec.s1     = s1_next;
    assign q_rec.s2     = s2_next;
    assign q_rec.cnt    = cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ped_count_reg   <= PED_COUNT_RST;
            window_low_reg  <= WINDOW_LOW_RST;
            window_high_reg <= WINDOW_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PED_COUNT:   ped_count_reg   <= cfg_data;
                REG_WINDOW_LOW:  window_low_reg  <= cfg_data;
                REG_WINDOW_HIGH: window_high_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            total_reg  <= '0;
            window_reg <= '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
            best_reg   <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                // start the next waveform from zero
                idx_reg    <= '0;
                total_reg  <= '0;
                window_reg <= '0;
                s1_reg     <= '0;
                s2_reg     <= '0;
                best_reg   <= '0;
                pos_reg    <= '0;
            end
            else
            begin
                idx_reg    <= idx_next;
                total_reg  <= total_next;
                window_reg <= window_next;
                s1_reg     <= s1_next;
                s2_reg     <= s2_next;
                best_reg   <= best_next;
                pos_reg    <= pos_next;
            end
        end
    end

endmodule

[rtl/pwf_queue.sv]
// Short record queue between the front and back parts.
// Holds pwf_rec_t entries from pwf_pkg; read data comes from the head slot.
module pwf_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pwf_pkg::pwf_rec_t    push_rec,
    input  logic                 pop,
    output pwf_pkg::pwf_rec_t    head_rec,
    output pwf_pkg::pwf_qstat_t  stat
);
    import pwf_pkg::*;

    pwf_rec_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_rec   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/pwf_div.sv]
// Restoring divider, one quotient bit per cycle, shared by mean and variance.
// Request and response travel as pwf_pkg structs.
module pwf_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pwf_pkg::pwf_div_req_t req,
    output pwf_pkg::pwf_div_rsp_t rsp
);
    import pwf_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic [DIV_W-1:0]  quot_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  denom_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quot_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, denom_reg});

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
            denom_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                step_reg  <= '0;
                quot_reg  <= req.numer;
                rem_reg   <= '0;
                denom_reg <= req.denom;
            end
            else if (busy_reg)
            begin
                // shift in the next numerator bit, subtract where the divisor fits
                rem_reg  <= fits ? DEN_W'(trial - {1'b0, denom_reg}) : trial[DEN_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/pwf_back.sv]
// Back part: pedestal mean and spread from one queued record, then the result register.
// Uses the shared divider pwf_div through pwf_pkg structs.
module pwf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pwf_pkg::pwf_rec_t              head_rec,
    input  pwf_pkg::pwf_qstat_t            q_stat,
    output logic                           q_pop,
    output pwf_pkg::pwf_div_req_t          div_req,
    input  pwf_pkg::pwf_div_rsp_t          div_rsp,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pwf_pkg::M_DATA_W-1:0]   m_tdata
);
    import pwf_pkg::*;

    localparam int ROOT_STEP_W = $clog2(ROOT_W);
    localparam int REM_W       = ROOT_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIFF,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_VAR,
        ST_VAR_WAIT,
        ST_ROOT,
        ST_SEND
    } state_t;

    state_t                 state_reg;
    pwf_rec_t               rec_reg;
    logic [PROD_W-1:0]      prod_a_reg;
    logic [PROD_W-1:0]      prod_b_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [PROD_W-1:0]      diff_reg;
    logic [SUM_W-1:0]       mean_reg;
    logic [ROOT_W-1:0]      spread_reg;
    logic [PROD_W-1:0]      rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [ROOT_STEP_W-1:0] step_reg;
    logic                   div_start_reg;
    logic [DIV_W-1:0]       div_numer_reg;
    logic                   valid_reg;
    logic [REM_W+1:0]       rem_sh;
    logic [REM_W+1:0]       trial;
    logic                   fits;

    assign rem_sh = {rem_reg, rad_reg[PROD_W-1 -: 2]};
    assign trial  = {spread_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    assign q_pop         = (state_reg == ST_IDLE) && !q_stat.empty;
    assign div_req.start = div_start_reg;
    assign div_req.numer = div_numer_reg;
    assign div_req.denom = den_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0, spread_reg, mean_reg, rec_reg.pos, rec_reg.peak,
                       rec_reg.window, rec_reg.total};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rec_reg       <= '0;
            prod_a_reg    <= '0;
            prod_b_reg    <= '0;
            den_reg       <= '0;
            diff_reg      <= '0;
            mean_reg      <= '0;
            spread_reg    <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            div_start_reg <= 1'b0;
            div_numer_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        rec_reg   <= head_rec;
                        state_reg <= ST_MULT;
                    end
                end
                ST_MULT:
                begin
                    prod_a_reg <= PROD_W'(rec_reg.cnt) * PROD_W'(rec_reg.s2);
                    prod_b_reg <= PROD_W'(rec_reg.s1) * PROD_W'(rec_reg.s1);
                    den_reg    <= DEN_W'(rec_reg.cnt) * (DEN_W'(rec_reg.cnt) - 1'b1);
                    mean_reg   <= '0;
                    spread_reg <= '0;
                    state_reg  <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    diff_reg  <= (prod_a_reg > prod_b_reg) ? prod_a_reg - prod_b_reg : '0;
                    state_reg <= (rec_reg.cnt != '0) ? ST_MEAN : ST_SEND;
                    valid_reg <= (rec_reg.cnt == '0);
                end
                ST_MEAN:
                begin
                    // mean = 256 * S1 / cnt; the divisor port carries cnt for this pass
                    den_reg       <= DEN_W'(rec_reg.cnt);
                    div_numer_reg <= DIV_W'({rec_reg.s1, 8'b0});
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg <= div_rsp.quot[SUM_W-1:0];
                        if (rec_reg.cnt >= CNT_W'(2))
                            state_reg <= ST_VAR;
                        else
                        begin
                            state_reg <= ST_SEND;
                            valid_reg <= 1'b1;
                        end
                    end
                end
                ST_VAR:
                begin
                    den_reg       <= DEN_W'(rec_reg.cnt) * (DEN_W'(rec_reg.cnt) - 1'b1);
                    div_numer_reg <= {diff_reg, 16'b0};
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_VAR_WAIT;
                end
                ST_VAR_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        rad_reg   <= div_rsp.quot[PROD_W-1:0];
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    // one root bit per cycle from the top two radicand bits
                    rad_reg    <= {rad_reg[PROD_W-3:0], 2'b00};
                    rem_reg    <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                    spread_reg <= {spread_reg[ROOT_W-2:0], fits};
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == ROOT_STEP_W'(ROOT_W - 1))
                    begin
                        state_reg <= ST_SEND;
                        valid_reg <= 1'b1;
                    end
                end
                ST_SEND:
                begin
                    if (m_tready)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

[rtl/pulse_waveform_features_unit.sv]
// Pulse waveform feature unit: one record of sums, peak and pedestal per waveform.
// Uses pwf_pkg and instantiates pwf_front, pwf_queue, pwf_div and pwf_back.
//
// Usage:
//   Samples enter on the s_ channel, one per cycle while s_tready is high, with s_tlast on the final
//   sample of a waveform. Samples past index 255 are dropped, but their tlast
//   still closes the waveform. Each closed waveform gives one record on m_.
//   The cfg channel writes ped_count (0), window_low (1), window_high (2);
//   index 3 is ignored. cfg_ready is always high; write only while idle.
// Processing:
//   The front accumulates one sample per cycle while the queue has room. After tlast,
//   a record waits in a two-entry queue; the back part then runs two passes of the
//   shared bit-serial divider and a square root on it, with fewer steps when the pedestal
//   count is below two. The iterative divider sets the record rate.
// Reset and stalls:
//   Reset restores the register defaults (125, 126, 255), clears accumulators
//   and the queue. When m_tready is low the result holds in the output register
//   while the front keeps taking samples until the queue fills; s_tready then
//   drops until the back part frees an entry.
module pulse_waveform_features_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pwf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwf_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [11:0] adc_sample, [15:12] zero
    input  logic [pwf_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [19:0] total_sum, [39:20] window_total, [51:40] peak_value,
    // [59:52] peak_position, [79:60] pedestal_mean, [99:80] pedestal_spread, [103:100] zero
    output logic [pwf_pkg::M_DATA_W-1:0]   m_tdata
);
    import pwf_pkg::*;

    pwf_qstat_t   q_stat;
    pwf_rec_t     push_rec;
    pwf_rec_t     head_rec;
    logic         q_push;
    logic         q_pop;
    pwf_div_req_t div_req;
    pwf_div_rsp_t div_rsp;

    pwf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    pwf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .stat     (q_stat)
    );

    pwf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pwf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("record pushed into a full queue");

    a_record_queued : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !q_stat.empty)
        else $error("closed waveform left no record in the queue");

    a_div_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider finished without running");

    a_no_start_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

[verif/pwf_feature_checker.sv]
// Feature checker for pulse_waveform_features_unit: watches the cfg, s_ and m_ channels,
// predicts one feature record per closed waveform and compares it with what comes out.
// Depends on pwf_pkg for widths and register indexes.
module pwf_feature_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pwf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pwf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [pwf_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pwf_pkg::M_DATA_W-1:0]  m_tdata,
    output int                            pending,
    output int                            fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned OUT_MAX = (64'd1 << pwf_pkg::SUM_W) - 1;

    // Packed so that total_sum lands in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [19:0] spread;
        logic [19:0] mean;
        logic [7:0]  pos;
        logic [11:0] peak;
        logic [19:0] window;
        logic [19:0] total;
    } feature_rec_t;

    feature_rec_t expected_records[$];

    int              ped_count;
    int              win_lo;
    int              win_hi;
    int              wave_idx;
    longint unsigned acc_total;
    longint unsigned acc_window;
    longint unsigned ped_sum;
    longint unsigned ped_sq_sum;
    longint unsigned peak_val;
    int              peak_pos;
    int              errors;

    function automatic longint unsigned sat_out(longint unsigned v);
        return (v > OUT_MAX) ? OUT_MAX : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic clear_waveform();
        wave_idx   = 0;
        acc_total  = 0;
        acc_window = 0;
        ped_sum    = 0;
        ped_sq_sum = 0;
        peak_val   = 0;
        peak_pos   = 0;
    endtask

    function automatic feature_rec_t close_waveform();
        feature_rec_t    rec;
        longint unsigned cnt;
        longint unsigned mean;
        longint unsigned spread;
        longint unsigned sq_term;
        longint unsigned lin_term;
        longint unsigned diff;
        cnt    = (wave_idx < ped_count) ? wave_idx : ped_count;
        mean   = 0;
        spread = 0;
        if (cnt != 0)
            mean = (ped_sum * 256) / cnt;
        // sample variance needs two pedestal samples at least
        if (cnt >= 2)
        begin
            sq_term  = cnt * ped_sq_sum;
            lin_term = ped_sum * ped_sum;
            diff     = (sq_term > lin_term) ? sq_term - lin_term : 0;
            spread   = floor_sqrt((diff * 65536) / (cnt * (cnt - 1)));
        end
        rec.total  = 20'(sat_out(acc_total));
        rec.window = 20'(sat_out(acc_window));
        rec.peak   = peak_val[11:0];
        rec.pos    = (peak_pos > 255) ? 8'd255 : peak_pos[7:0];
        rec.mean   = 20'(sat_out(mean));
        rec.spread = 20'(sat_out(spread));
        return rec;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        feature_rec_t    want;
        feature_rec_t    got;
        longint unsigned smp;
        if (!rst_n)
        begin
            ped_count = pwf_pkg::PED_COUNT_RST;
            win_lo    = pwf_pkg::WINDOW_LOW_RST;
            win_hi    = pwf_pkg::WINDOW_HIGH_RST;
            clear_waveform();
            expected_records.delete();
            errors     = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pwf_pkg::REG_PED_COUNT:   ped_count = cfg_data;
                    pwf_pkg::REG_WINDOW_LOW:  win_lo    = cfg_data;
                    pwf_pkg::REG_WINDOW_HIGH: win_hi    = cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got = feature_rec_t'(m_tdata[99:0]);
                if (expected_records.size() == 0)
                begin
                    $display("%0t: unexpected record, expected none, actual %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("total_sum", want.total, got.total);
                    check_field("window_total", want.window, got.window);
                    check_field("peak_value", want.peak, got.peak);
                    check_field("peak_position", want.pos, got.pos);
                    check_field("pedestal_mean", want.mean, got.mean);
                    check_field("pedestal_spread", want.spread, got.spread);
                    check_field("tdata padding", 0, m_tdata[103:100]);
                end
            end

            if (s_tvalid && s_tready)
            begin
                smp = s_tdata[pwf_pkg::SAMPLE_BITS-1:0];
                // drop samples past the record length, but still honor tlast
                if (wave_idx < pwf_pkg::MAX_SAMPLES)
                begin
                    acc_total += smp;
                    if (wave_idx >= win_lo && wave_idx <= win_hi)
                        acc_window += smp;
                    if (wave_idx < ped_count)
                    begin
                        ped_sum    += smp;
                        ped_sq_sum += smp * smp;
                    end
                    if (wave_idx == 0 || smp > peak_val)
                    begin
                        peak_val = smp;
                        peak_pos = wave_idx;
                    end
                    wave_idx++;
                end
                if (s_tlast)
                begin
                    expected_records.push_back(close_waveform());
                    clear_waveform();
                end
            end

            pending    <= expected_records.size();
            fail_count <= errors;
        end
    end

endmodule

[verif/tb_top.sv]
// Top of the pulse_waveform_features_unit testbench: clock, reset, configuration writes,
// sample stimulus and result back-pressure. Checking lives in pwf_feature_checker.
// Depends on pwf_pkg, the RTL top and verif/pwf_feature_checker.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 3000;
    localparam int ITEM_TARGET   = 1100;
    localparam int RECORD_TARGET = 40;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_FIXED     = 5;
    localparam int NUM_LONG      = 2;

    localparam logic [pwf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {SHAPE_RANDOM, SHAPE_RAIL, SHAPE_PULSE, SHAPE_FLAT} shape_t;

    // idle and stall percentages per traffic mode: none, sender, receiver, both
    localparam int IDLE_PCT[4]  = '{0, 87, 0, 34};
    localparam int STALL_PCT[4] = '{0, 0, 87, 34};

    localparam int FIX_PED[NUM_FIXED] = '{2, 255, 0, 1, 8};
    localparam int FIX_LO[NUM_FIXED]  = '{0, 255, 10, 200, 3};
    localparam int FIX_HI[NUM_FIXED]  = '{255, 0, 20, 255, 3};

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [pwf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pwf_pkg::CFG_W-1:0]     cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [pwf_pkg::S_DATA_W-1:0]  s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [pwf_pkg::M_DATA_W-1:0]  m_tdata;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int idle_pct;
    int stall_pct;
    int hold_seq;
    int hold_seen;
    int items_sent;
    int records_sent;

    pulse_waveform_features_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pwf_feature_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready  = 1'b0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic set_mode(int mode);
        idle_pct  = IDLE_PCT[mode];
        stall_pct = STALL_PCT[mode];
    endtask

    task automatic cfg_write(logic [pwf_pkg::CFG_IDX_W-1:0] idx, logic [pwf_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Hold the sample side until every record is out and the back stage is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(int ped, int lo, int hi);
        drain();
        cfg_write(pwf_pkg::REG_PED_COUNT, ped[7:0]);
        cfg_write(pwf_pkg::REG_WINDOW_LOW, lo[7:0]);
        cfg_write(pwf_pkg::REG_WINDOW_HIGH, hi[7:0]);
        cfg_write(REG_UNUSED, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [11:0] smp, logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (last)
            records_sent++;
    endtask

    task automatic send_waveform(int len);
        shape_t      shape;
        int          base;
        int          amp;
        int          pk;
        int          v;
        logic [11:0] smp;
        shape = shape_t'($urandom_range(0, 3));
        base  = $urandom_range(0, 600);
        amp   = $urandom_range(0, 3600);
        pk    = $urandom_range(0, len);
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_RANDOM: smp = 12'($urandom_range(0, 4095));
                SHAPE_RAIL:   smp = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                default:
                begin
                    v = base + $urandom_range(0, 15);
                    if (shape == SHAPE_PULSE && i >= pk && i < pk + 6)
                        v += amp;
                    smp = (v > 4095) ? 12'hFFF : v[11:0];
                end
            endcase
            send_sample(smp, i == len - 1);
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 12);
        if (r < 95)
            return $urandom_range(13, 80);
        if (r < 98)
            return $urandom_range(250, 300);
        return $urandom_range(255, 257);
    endfunction

    initial
    begin
        int ped;
        int lo;
        int hi;
        int tmp;
        int phase;
        int next_phase_at;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        hold_seq    = 0;
        items_sent  = 0;
        records_sent = 0;
        set_mode(0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: single-sample, all-zero, tied peak, rail and bit patterns
        send_sample(12'hFFF, 1'b1);
        send_sample(12'h000, 1'b1);
        send_sample(12'h000, 1'b0);
        send_sample(12'h000, 1'b0);
        send_sample(12'h000, 1'b1);
        send_sample(12'd5, 1'b0);
        send_sample(12'd9, 1'b0);
        send_sample(12'd9, 1'b0);
        send_sample(12'd2, 1'b1);
        send_sample(12'hFFF, 1'b0);
        send_sample(12'h000, 1'b1);
        send_sample(12'hAAA, 1'b0);
        send_sample(12'h555, 1'b0);
        send_sample(12'hFFF, 1'b0);
        send_sample(12'h000, 1'b1);

        for (int f = 0; f < NUM_FIXED; f++)
        begin
            set_config(FIX_PED[f], FIX_LO[f], FIX_HI[f]);
            set_mode(f % 4);
            for (int w = 0; w < 3; w++)
                send_waveform(pick_length());
            if (f < NUM_LONG)
                send_waveform(257);
        end

        // long hold-off on the result side while short waveforms keep coming
        set_config(8, 3, 3);
        set_mode(0);
        hold_seq = hold_seq + 1;
        for (int w = 0; w < 12; w++)
            send_waveform(3);

        phase = 0;
        next_phase_at = items_sent;
        while (items_sent < ITEM_TARGET || records_sent < RECORD_TARGET)
        begin
            if (items_sent >= next_phase_at)
            begin
                ped = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
                lo  = $urandom_range(0, 255);
                hi  = $urandom_range(0, 255);
                if (lo > hi && $urandom_range(0, 3) != 0)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                set_config(ped, lo, hi);
                set_mode(phase % 4);
                phase++;
                next_phase_at = items_sent + PHASE_ITEMS;
            end
            send_waveform(pick_length());
        end

        drain();
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[pulse_waveform_features_unit.f]
rtl/pwf_pkg.sv
rtl/pwf_front.sv
rtl/pwf_queue.sv
rtl/pwf_div.sv
rtl/pwf_back.sv
rtl/pulse_waveform_features_unit.sv
verif/pwf_feature_checker.sv
verif/tb_top.sv
